// ===== hdl/rfs_pkg.sv =====
// ----------------------------------------------------------------------------
// Rocket flight sequencer package
// Shared payload, configuration and state types, mode and beep codes, and
// the conversion of the internal one-hot mode to its numeric code.
// ----------------------------------------------------------------------------
package rfs_pkg;

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_ARM   = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;
  localparam logic [1:0] OP_CHECK = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_DROGUE_PROTECT = 3'd0;
  localparam logic [2:0] REG_DROGUE_FORCE   = 3'd1;
  localparam logic [2:0] REG_MAIN_PROTECT   = 3'd2;
  localparam logic [2:0] REG_MAIN_FORCE     = 3'd3;
  localparam logic [2:0] REG_LANDING        = 3'd4;
  localparam logic [2:0] REG_BURNOUT_MIN    = 3'd5;
  localparam logic [2:0] REG_ANNOUNCE_LEAD  = 3'd6;
  localparam logic [2:0] REG_MAIN_ALTITUDE  = 3'd7;

  // Beep event bit positions.
  localparam int unsigned BEEP_ONCE  = 0;
  localparam int unsigned BEEP_LONG  = 1;
  localparam int unsigned BEEP_TWICE = 2;
  localparam int unsigned BEEP_ATTN  = 3;
  localparam int unsigned BEEP_LONG3 = 4;
  localparam int unsigned BEEP_WARN  = 5;

  // Landed to shutdown delay on top of the landing time.
  localparam logic [16:0] SHUTDOWN_DELAY_MS = 17'd5000;

  // Numeric mode codes as they appear on the result channel.
  localparam logic [3:0] CODE_STANDBY      = 4'd0;
  localparam logic [3:0] CODE_READY        = 4'd1;
  localparam logic [3:0] CODE_POWERED      = 4'd2;
  localparam logic [3:0] CODE_FREE_CLIMB   = 4'd3;
  localparam logic [3:0] CODE_FREE_DESCENT = 4'd4;
  localparam logic [3:0] CODE_DROGUE       = 4'd5;
  localparam logic [3:0] CODE_MAIN         = 4'd6;
  localparam logic [3:0] CODE_LANDED       = 4'd7;
  localparam logic [3:0] CODE_SHUTDOWN     = 4'd8;
  localparam logic [3:0] CODE_PROTECT      = 4'd9;

  // Flight mode, one-hot.
  typedef enum logic [9:0] {
    M_STANDBY      = 10'b00_0000_0001,
    M_READY        = 10'b00_0000_0010,
    M_POWERED      = 10'b00_0000_0100,
    M_FREE_CLIMB   = 10'b00_0000_1000,
    M_FREE_DESCENT = 10'b00_0001_0000,
    M_DROGUE       = 10'b00_0010_0000,
    M_MAIN         = 10'b00_0100_0000,
    M_LANDED       = 10'b00_1000_0000,
    M_SHUTDOWN     = 10'b01_0000_0000,
    M_PROTECT      = 10'b10_0000_0000
  } mode_t;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0]         operation;
    logic [31:0]        now_ms;
    logic               pin_open;
    logic               launch_mode;
    logic               ignition;
    logic               falling;
    logic signed [15:0] altitude_m;
    logic signed [15:0] axial_force_n;
    logic signed [15:0] axial_jerk;
  } rfs_in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [3:0]  mode;
    logic [31:0] elapsed_ms;
    logic        fire_drogue;
    logic        fire_main;
    logic [5:0]  beep_events;
    logic        logging;
    logic        logging_changed;
  } rfs_out_t;

  // Configuration register set.
  typedef struct packed {
    logic [15:0]        drogue_protect_ms;
    logic [15:0]        drogue_force_ms;
    logic [15:0]        main_protect_ms;
    logic [15:0]        main_force_ms;
    logic [15:0]        landing_ms;
    logic [15:0]        burnout_min_ms;
    logic [15:0]        announce_lead_ms;
    logic signed [15:0] main_altitude_m;
  } rfs_cfg_t;

  // Sequencer state carried from one transaction to the next.
  typedef struct packed {
    mode_t       mode;
    logic [31:0] launch_time;
    logic        drogue_announced;
    logic        main_announced;
    logic        logging;
  } rfs_state_t;

  // Map the one-hot mode to its numeric code.
  function automatic logic [3:0] mode_code(input mode_t m);
    logic [3:0] code;
    code = CODE_STANDBY;
    unique case (m)
      M_STANDBY:      code = CODE_STANDBY;
      M_READY:        code = CODE_READY;
      M_POWERED:      code = CODE_POWERED;
      M_FREE_CLIMB:   code = CODE_FREE_CLIMB;
      M_FREE_DESCENT: code = CODE_FREE_DESCENT;
      M_DROGUE:       code = CODE_DROGUE;
      M_MAIN:         code = CODE_MAIN;
      M_LANDED:       code = CODE_LANDED;
      M_SHUTDOWN:     code = CODE_SHUTDOWN;
      M_PROTECT:      code = CODE_PROTECT;
      default:        code = CODE_STANDBY;
    endcase
    return code;
  endfunction

endpackage

// ===== hdl/rocket_flight_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// Rocket flight sequencer top level
// Input register, sequencer state, step logic and result register.
// ----------------------------------------------------------------------------
// Usage:
// Input transactions (tick, arm, reset command, power-on check) enter on the
// in_ valid/ready channel; every transaction yields exactly one result
// transaction on the out_ channel, in order. Configuration registers are
// written on the cfg_ channel, which is always ready; write them only while
// no transaction is in flight.
// Flow: a transaction accepted into the input register is evaluated against
// the state in one combinational pass, and its result is captured in the
// result register, which drives out_valid until the result is taken.
// The state update and the result capture share the same edge, so one
// transaction per cycle is sustained while out_ready stays high.
// Stall: when the receiver holds out_ready low, the result register holds;
// one more transaction is taken into the input register, then in_ready
// drops until the result is taken.
// Reset (synchronous, rst_n low): both registers empty, mode standby,
// launch time zero, announcement and logging flags cleared, configuration
// back to its defaults.
// ----------------------------------------------------------------------------
module rocket_flight_sequencer_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rfs_pkg::rfs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rfs_pkg::rfs_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import rfs_pkg::*;

  rfs_in_t    in_r;
  logic       in_vld_r;
  rfs_out_t   out_r;
  logic       out_vld_r;
  rfs_state_t st_r;
  rfs_state_t st_nxt;
  rfs_out_t   res;
  rfs_cfg_t   cfg;
  logic       advance;

  // Configuration registers.
  rfs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Step logic between the input register and the result register.
  rfs_step u_step (
    .st     (st_r),
    .item   (in_r),
    .cfg    (cfg),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // The held transaction moves on when the result register is free or drains.
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r              <= 1'b0;
      out_vld_r             <= 1'b0;
      st_r.mode             <= M_STANDBY;
      st_r.launch_time      <= '0;
      st_r.drogue_announced <= 1'b0;
      st_r.main_announced   <= 1'b0;
      st_r.logging          <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
        st_r      <= st_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // Data protection is only left through reset.
  a_protect_sticky : assert property (@(posedge clk) disable iff (!rst_n)
    st_r.mode == M_PROTECT |=> st_r.mode == M_PROTECT)
    else $error("left data protection without reset");

  // Commands and checks never report a logging change.
  a_log_tick_only : assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_r.operation != OP_TICK |=> !out_r.logging_changed)
    else $error("logging change reported on a non-tick transaction");

  // Every separation firing comes with the double beep.
  a_fire_beep : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_r.fire_drogue || out_r.fire_main) |-> out_r.beep_events[BEEP_TWICE])
    else $error("separation fired without double beep");

endmodule

// ===== hdl/rfs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Rocket flight sequencer configuration registers
// Eight 16-bit timing and altitude registers, written by index, with their
// default values restored at reset.
// ----------------------------------------------------------------------------
module rfs_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [15:0]     cfg_data,
  output rfs_pkg::rfs_cfg_t cfg
);
  import rfs_pkg::*;

  rfs_cfg_t cfg_r;

  // Writes are taken in any cycle.
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Register file with reset defaults.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.drogue_protect_ms <= 16'd23000;
      cfg_r.drogue_force_ms   <= 16'd30000;
      cfg_r.main_protect_ms   <= 16'd40000;
      cfg_r.main_force_ms     <= 16'd45000;
      cfg_r.landing_ms        <= 16'd50000;
      cfg_r.burnout_min_ms    <= 16'd2000;
      cfg_r.announce_lead_ms  <= 16'd300;
      cfg_r.main_altitude_m   <= 16'sd100;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DROGUE_PROTECT: cfg_r.drogue_protect_ms <= cfg_data;
        REG_DROGUE_FORCE:   cfg_r.drogue_force_ms   <= cfg_data;
        REG_MAIN_PROTECT:   cfg_r.main_protect_ms   <= cfg_data;
        REG_MAIN_FORCE:     cfg_r.main_force_ms     <= cfg_data;
        REG_LANDING:        cfg_r.landing_ms        <= cfg_data;
        REG_BURNOUT_MIN:    cfg_r.burnout_min_ms    <= cfg_data;
        REG_ANNOUNCE_LEAD:  cfg_r.announce_lead_ms  <= cfg_data;
        REG_MAIN_ALTITUDE:  cfg_r.main_altitude_m   <= cfg_data;
      endcase
    end
  end

endmodule

// ===== hdl/rfs_step.sv =====
// ----------------------------------------------------------------------------
// Rocket flight sequencer step logic
// Combinational evaluation of one transaction against the current state:
// commands, forced separations with their announcements, and the mode
// transition, giving the next state and the result.
// ----------------------------------------------------------------------------
module rfs_step (
  input  rfs_pkg::rfs_state_t st,
  input  rfs_pkg::rfs_in_t    item,
  input  rfs_pkg::rfs_cfg_t   cfg,
  output rfs_pkg::rfs_state_t st_nxt,
  output rfs_pkg::rfs_out_t   res
);
  import rfs_pkg::*;

  mode_t       m;
  logic [31:0] lt;
  logic        da;
  logic        ma;
  logic        lg;
  logic [5:0]  beeps;
  logic        fd;
  logic        fm;
  logic        chg;
  logic        climb;
  logic        log_on;
  logic [31:0] el;
  logic [15:0] thr_drogue;
  logic [15:0] thr_main;
  logic [16:0] shutdown_ms;

  // Announcement thresholds saturate at zero when the lead exceeds the force time.
  assign thr_drogue = (cfg.drogue_force_ms >= cfg.announce_lead_ms) ?
                      cfg.drogue_force_ms - cfg.announce_lead_ms : 16'd0;
  assign thr_main   = (cfg.main_force_ms >= cfg.announce_lead_ms) ?
                      cfg.main_force_ms - cfg.announce_lead_ms : 16'd0;
  assign shutdown_ms = {1'b0, cfg.landing_ms} + SHUTDOWN_DELAY_MS;

  // Flight time since launch, from the launch time before this transaction.
  assign el = item.now_ms - st.launch_time;

  always_comb begin
    m      = st.mode;
    lt     = st.launch_time;
    da     = st.drogue_announced;
    ma     = st.main_announced;
    lg     = st.logging;
    beeps  = '0;
    fd     = 1'b0;
    fm     = 1'b0;
    chg    = 1'b0;
    climb  = 1'b0;
    log_on = 1'b0;

    unique case (item.operation)
      OP_ARM: begin
        if (m == M_STANDBY) begin
          m = M_READY;
          da = 1'b0;
          ma = 1'b0;
          beeps[BEEP_LONG] = 1'b1;
        end
      end
      OP_RESET: begin
        if (m != M_STANDBY && m != M_PROTECT) begin
          m = M_STANDBY;
          beeps[BEEP_LONG] = 1'b1;
        end
      end
      OP_CHECK: begin
        if (item.pin_open) begin
          m = M_PROTECT;
          beeps[BEEP_WARN] = 1'b1;
        end
      end
      OP_TICK: begin
        if (m != M_PROTECT) begin
          // A closed pin in any mode past ready drops back to standby.
          if (m != M_STANDBY && m != M_READY && !item.pin_open) begin
            m = M_STANDBY;
            beeps[BEEP_LONG] = 1'b1;
          end

          // Forced drogue separation and its announcement.
          climb = (m == M_POWERED) || (m == M_FREE_CLIMB) || (m == M_FREE_DESCENT);
          if (!da && climb && el >= {16'd0, thr_drogue}) begin
            da = 1'b1;
            beeps[BEEP_ATTN] = 1'b1;
          end
          if (climb && el >= {16'd0, cfg.drogue_force_ms}) begin
            m = M_DROGUE;
            fd = 1'b1;
            beeps[BEEP_TWICE] = 1'b1;
          end

          // Forced main separation and its announcement.
          if (!ma && m == M_DROGUE && el >= {16'd0, thr_main}) begin
            ma = 1'b1;
            beeps[BEEP_ATTN] = 1'b1;
          end
          if (m == M_DROGUE && el >= {16'd0, cfg.main_force_ms}) begin
            m = M_MAIN;
            fm = 1'b1;
            beeps[BEEP_TWICE] = 1'b1;
          end

          // Regular transition of the resulting mode.
          unique case (m)
            M_STANDBY: begin
              if (item.pin_open || item.launch_mode || item.ignition) begin
                m = M_READY;
                da = 1'b0;
                ma = 1'b0;
                beeps[BEEP_LONG] = 1'b1;
              end
            end
            M_READY: begin
              if (item.pin_open) begin
                m = M_POWERED;
                lt = item.now_ms;
                beeps[BEEP_ONCE] = 1'b1;
              end
            end
            M_POWERED: begin
              if (el >= {16'd0, cfg.burnout_min_ms} && item.axial_force_n[15] &&
                  item.axial_jerk[15]) begin
                m = M_FREE_CLIMB;
              end
            end
            M_FREE_CLIMB: begin
              if (item.falling) begin
                m = M_FREE_DESCENT;
              end
            end
            M_FREE_DESCENT: begin
              if (el >= {16'd0, cfg.drogue_protect_ms}) begin
                m = M_DROGUE;
                fd = 1'b1;
                beeps[BEEP_TWICE] = 1'b1;
              end
            end
            M_DROGUE: begin
              if (el >= {16'd0, cfg.main_protect_ms} &&
                  item.altitude_m < cfg.main_altitude_m) begin
                m = M_MAIN;
                fm = 1'b1;
                beeps[BEEP_TWICE] = 1'b1;
              end
            end
            M_MAIN: begin
              if (el >= {16'd0, cfg.landing_ms}) begin
                m = M_LANDED;
                beeps[BEEP_LONG3] = 1'b1;
              end
            end
            M_LANDED: begin
              if (el >= {15'd0, shutdown_ms}) begin
                m = M_SHUTDOWN;
              end
            end
            default: begin
            end
          endcase

          // Logging runs from ready through shutdown.
          log_on = (m != M_STANDBY) && (m != M_PROTECT);
          chg    = log_on != lg;
          lg     = log_on;
        end
      end
    endcase
  end

  // Next state and result.
  assign st_nxt.mode             = m;
  assign st_nxt.launch_time      = lt;
  assign st_nxt.drogue_announced = da;
  assign st_nxt.main_announced   = ma;
  assign st_nxt.logging          = lg;

  assign res.mode            = mode_code(m);
  assign res.elapsed_ms      = item.now_ms - lt;
  assign res.fire_drogue     = fd;
  assign res.fire_main       = fm;
  assign res.beep_events     = beeps;
  assign res.logging         = lg;
  assign res.logging_changed = chg;

endmodule
